// ===== hw/rtl/ssps_pkg.sv =====
// Shared types and constants for the sine series partial sum block.
package ssps_pkg;

    // Field widths of the request and result items.
    localparam int X_W   = 5;
    localparam int N_W   = 6;
    localparam int SUM_W = 48;

    // Non-negative argument magnitude, power and factorial widths.
    localparam int XM_W  = 4;
    localparam int P_W   = 63;

    // Rounded term width: a term is clamped to 2^58, so it needs 59 bits.
    localparam int Q_W   = 59;

    // Accumulator width: ten terms of at most 2^58 stay well inside 64 bits.
    localparam int ACC_W = 64;

    localparam logic [Q_W-1:0] TERM_CAP = {1'b1, {(Q_W-1){1'b0}}};

    localparam logic signed [ACC_W-1:0] ACC_SUM_MAX = 64'sd140737488355327;
    localparam logic signed [ACC_W-1:0] ACC_SUM_MIN = -64'sd140737488355328;

endpackage

// ===== hw/rtl/ssps_if.sv =====
// Request and result channel interfaces of the sine series partial sum block.
interface ssps_in_if
    import ssps_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [X_W-1:0]   x_value;
    logic signed [N_W-1:0]   term_limit;

    modport source (output valid, output x_value, output term_limit, input ready);
    modport sink   (input valid, input x_value, input term_limit, output ready);
endinterface

interface ssps_out_if
    import ssps_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    err_x_negative;
    logic                    err_n_negative;
    logic                    err_n_even;
    logic                    overflow;
    logic signed [SUM_W-1:0] series_sum;

    modport source (output valid, output err_x_negative, output err_n_negative,
                    output err_n_even, output overflow, output series_sum, input ready);
    modport sink   (input valid, input err_x_negative, input err_n_negative,
                    input err_n_even, input overflow, input series_sum, output ready);
endinterface

// ===== hw/rtl/ssps_div.sv =====
// Bit-serial restoring divider that forms round(num * 2^FRAC_BITS / den), clamped.
module ssps_div
    import ssps_pkg::*;
#(
    parameter int FRAC_BITS = 32
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [P_W-1:0] num,
    input  logic [P_W-1:0] den,
    output logic           done,
    output logic [Q_W-1:0] term
);

    // Integer quotient bits, then one more fraction bit than kept for rounding.
    localparam int STEPS = P_W + FRAC_BITS + 1;
    localparam int CNT_W = $clog2(STEPS);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [P_W-1:0]   rem_reg, rem_next;
    logic [P_W-1:0]   dvd_reg, dvd_next;
    logic [P_W-1:0]   den_reg, den_next;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic             big_reg, big_next;

    logic [P_W:0]     trial;
    logic             fits;
    logic [Q_W:0]     rounded;

    // One compare-subtract step per cycle.
    assign trial = {rem_reg, dvd_reg[P_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        big_next  = big_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = num;
            den_next  = den;
            quo_next  = '0;
            big_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? P_W'(trial - {1'b0, den_reg}) : trial[P_W-1:0];
            dvd_next = {dvd_reg[P_W-2:0], 1'b0};
            // A quotient bit shifted past the top means the term saturates.
            big_next = big_reg | quo_reg[Q_W-1];
            quo_next = {quo_reg[Q_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        big_reg <= big_next;
    end

    // Round half up by dropping the extra fraction bit; the result tops out at the cap.
    assign rounded = {1'b0, quo_reg} + {{Q_W{1'b0}}, 1'b1};
    assign term    = big_reg ? TERM_CAP : rounded[Q_W:1];
    assign done    = done_reg;

endmodule

// ===== hw/rtl/sine_series_partial_sum.sv =====
// Sine Taylor series partial sum: sequencer, power and factorial registers, accumulator.
//
// Usage: arg_chan carries a request with x_value and term_limit; sum_chan returns one
// result per request with three input error flags, an overflow flag and series_sum,
// the sum of +x^1/1! - x^3/3! + ... up to x^n/n! in fixed point with FRAC_BITS
// fraction bits. Both channels use valid/ready; a transfer happens when both are high.
//
// A request with an error flag, or with term_limit above MAX_N, skips the series and
// goes straight to the result. Otherwise every power k = 1..n takes one multiply step,
// and each odd power adds one pass of the shared bit-serial divider. One request is in
// work at a time, and arg_chan.ready is high only while the sequencer is idle.
//
// The result sits in an output register, so a new request is accepted while an
// earlier result waits for sum_chan.ready; a finished result holds in the sequencer
// until that register frees up. Reset empties the output register and idles the block.
module sine_series_partial_sum
    import ssps_pkg::*;
#(
    parameter int MAX_N     = 19,
    parameter int FRAC_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    ssps_in_if.sink     arg_chan,
    ssps_out_if.source  sum_chan
);

    localparam int K_W = $clog2(MAX_N + 1);
    localparam logic [N_W-1:0] LIMIT_MAX = N_W'(MAX_N);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } seq_state_t;

    seq_state_t               state_reg, state_next;
    logic [XM_W-1:0]          x_reg, x_next;
    logic [K_W-1:0]           n_reg, n_next;
    logic [K_W-1:0]           k_reg, k_next;
    logic [P_W-1:0]           p_reg, p_next;
    logic [P_W-1:0]           f_reg, f_next;
    logic signed [ACC_W-1:0]  sum_reg, sum_next;
    logic                     plus_reg, plus_next;
    logic                     ex_reg, ex_next;
    logic                     en_reg, en_next;
    logic                     ee_reg, ee_next;
    logic                     ovf_reg, ovf_next;

    logic                     out_valid_reg, out_valid_next;
    logic                     out_ex_reg, out_en_reg, out_ee_reg, out_ovf_reg;
    logic signed [SUM_W-1:0]  out_sum_reg;

    logic                     in_ex, in_en, in_ee, in_err, in_big;
    logic [P_W+XM_W-1:0]      p_prod;
    logic [P_W+K_W:0]         f_prod;
    logic                     mul_ovf;
    logic                     div_start;
    logic                     div_done;
    logic [Q_W-1:0]           div_term;
    logic signed [ACC_W-1:0]  term_ext;
    logic signed [SUM_W-1:0]  sum_sat;
    logic                     out_load;
    logic                     accept;

    // Request checks.
    assign in_ex  = arg_chan.x_value[X_W-1];
    assign in_en  = arg_chan.term_limit[N_W-1];
    assign in_ee  = ~arg_chan.term_limit[0];
    assign in_err = in_ex | in_en | in_ee;
    assign in_big = arg_chan.term_limit > LIMIT_MAX;
    assign accept = arg_chan.valid && (state_reg == S_IDLE);

    // Next power and factorial; anything above 2^63 - 1 is an overflow.
    assign p_prod  = (P_W+XM_W)'(p_reg) * (P_W+XM_W)'(x_reg);
    assign f_prod  = (P_W+K_W+1)'(f_reg) * (P_W+K_W+1)'(k_reg);
    assign mul_ovf = (|p_prod[P_W+XM_W-1:P_W]) | (|f_prod[P_W+K_W:P_W]);

    assign div_start = (state_reg == S_MUL) && !mul_ovf && k_reg[0];

    ssps_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (p_prod[P_W-1:0]),
        .den   (f_prod[P_W-1:0]),
        .done  (div_done),
        .term  (div_term)
    );

    assign term_ext = {{(ACC_W-Q_W){1'b0}}, div_term};

    // Clamp the accumulator to the result width.
    always_comb
    begin
        if (sum_reg > ACC_SUM_MAX)
        begin
            sum_sat = SUM_W'(ACC_SUM_MAX);
        end
        else if (sum_reg < ACC_SUM_MIN)
        begin
            sum_sat = SUM_W'(ACC_SUM_MIN);
        end
        else
        begin
            sum_sat = sum_reg[SUM_W-1:0];
        end
    end

    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || sum_chan.ready);

    // Sequencer over the powers of x.
    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        p_next     = p_reg;
        f_next     = f_reg;
        sum_next   = sum_reg;
        plus_next  = plus_reg;
        ex_next    = ex_reg;
        en_next    = en_reg;
        ee_next    = ee_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ex_next   = in_ex;
                    en_next   = in_en;
                    ee_next   = in_ee;
                    ovf_next  = !in_err && in_big;
                    x_next    = arg_chan.x_value[XM_W-1:0];
                    n_next    = arg_chan.term_limit[K_W-1:0];
                    k_next    = K_W'(1);
                    p_next    = P_W'(1);
                    f_next    = P_W'(1);
                    sum_next  = '0;
                    plus_next = 1'b1;
                    state_next = (in_err || in_big) ? S_FIN : S_MUL;
                end
            end
            S_MUL:
            begin
                if (mul_ovf)
                begin
                    ovf_next   = 1'b1;
                    sum_next   = '0;
                    state_next = S_FIN;
                end
                else
                begin
                    p_next = p_prod[P_W-1:0];
                    f_next = f_prod[P_W-1:0];
                    if (k_reg[0])
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        // An even power never ends the series: the limit is odd.
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    sum_next  = plus_reg ? (sum_reg + term_ext) : (sum_reg - term_ext);
                    plus_next = !plus_reg;
                    if (k_reg == n_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (sum_chan.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        n_reg    <= n_next;
        k_reg    <= k_next;
        p_reg    <= p_next;
        f_reg    <= f_next;
        sum_reg  <= sum_next;
        plus_reg <= plus_next;
        ex_reg   <= ex_next;
        en_reg   <= en_next;
        ee_reg   <= ee_next;
        ovf_reg  <= ovf_next;
    end

    // Result payload, loaded when the output register is free.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ex_reg  <= ex_reg;
            out_en_reg  <= en_reg;
            out_ee_reg  <= ee_reg;
            out_ovf_reg <= ovf_reg;
            out_sum_reg <= ovf_reg ? '0 : sum_sat;
        end
    end

    assign arg_chan.ready          = (state_reg == S_IDLE);
    assign sum_chan.valid          = out_valid_reg;
    assign sum_chan.err_x_negative = out_ex_reg;
    assign sum_chan.err_n_negative = out_en_reg;
    assign sum_chan.err_n_even     = out_ee_reg;
    assign sum_chan.overflow       = out_ovf_reg;
    assign sum_chan.series_sum     = out_sum_reg;

`ifndef SYNTHESIS
    // A request with an input error or an oversized limit goes straight to the result.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_err || in_big) |=> state_reg == S_FIN)
        else $error("bad request did not skip the series");

    // The divider only reports while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    // An error flag forces a zero sum and no overflow.
    assert property (@(posedge clk) disable iff (!rst_n)
        sum_chan.valid && (sum_chan.err_x_negative || sum_chan.err_n_negative ||
                           sum_chan.err_n_even)
        |-> !sum_chan.overflow && sum_chan.series_sum == '0)
        else $error("error result carries a sum or overflow");

    // Overflow forces a zero sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        sum_chan.valid && sum_chan.overflow |-> sum_chan.series_sum == '0)
        else $error("overflow result carries a sum");
`endif

endmodule
